// ===== sv/smlv_pkg.sv =====
`default_nettype none
package smlv_pkg;

    localparam int SYNTH_W = 19;
    localparam int DAC_W   = 16;
    localparam int RAW_W   = 20;   // synth + dac always fits
    localparam int SUM_W   = 22;   // raw plus three history slots
    localparam int MAG_W   = 20;   // magnitude after averaging
    localparam int PROD_W  = 30;   // signed average times volume
    localparam int OUT_W   = 16;
    localparam int HIST_D  = 3;

    // floor(x / 3) == (x * RECIP3) >> RECIP3_SH for x < 2**20
    localparam int RECIP3_W  = 21;
    localparam int RECIP3_SH = 22;
    localparam logic [RECIP3_W-1:0] RECIP3 = 21'd1398102;

    localparam int VOL_SH = 5;     // volume scale of 32

    localparam logic signed [PROD_W-1:0] OUT_MAX = 30'sd32767;
    localparam logic signed [PROD_W-1:0] OUT_MIN = -30'sd32768;

    // filter_mode codes; code 3 behaves as pass-through
    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_AVG3 = 2'd1;
    localparam logic [1:0] MODE_AVG4 = 2'd2;

    // history slot codes
    localparam logic [1:0] SLOT_0 = 2'd0;
    localparam logic [1:0] SLOT_1 = 2'd1;
    localparam logic [1:0] SLOT_2 = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FILTER_MODE  = 2'd0;
    localparam logic [1:0] CFG_VOLUME_MUL   = 2'd1;
    localparam logic [1:0] CFG_SYNTH_ENABLE = 2'd2;

    localparam logic [7:0] VOLUME_RESET = 8'd32;

    typedef struct packed {
        logic       ld_a;       // transaction accepted: mix, sum, history write
        logic       ld_b;       // advance averaging stage
        logic       ld_c;       // advance volume stage
        logic       synth_en;
        logic       dac_valid;
        logic [1:0] mode;
        logic [1:0] slot;
        logic [7:0] vol;
    } lane_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/smlv_lane.sv =====
`default_nettype none
module smlv_lane (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire smlv_pkg::lane_ctrl_t                ctrl,
    input  wire logic signed [smlv_pkg::SYNTH_W-1:0] synth,
    input  wire logic signed [smlv_pkg::DAC_W-1:0]   dac,
    output logic signed [smlv_pkg::OUT_W-1:0]        sample
);

    logic signed [smlv_pkg::RAW_W-1:0]  hist_reg [smlv_pkg::HIST_D];
    logic signed [smlv_pkg::RAW_W-1:0]  raw;
    logic signed [smlv_pkg::SUM_W-1:0]  sum_next;
    logic signed [smlv_pkg::SUM_W-1:0]  sum_reg;
    logic [1:0]                         mode_reg;

    logic [smlv_pkg::SUM_W-1:0]         mag_full;
    logic [smlv_pkg::MAG_W+smlv_pkg::RECIP3_W-1:0] prod3;
    logic [smlv_pkg::MAG_W-1:0]         mag_next;
    logic [smlv_pkg::MAG_W-1:0]         mag_reg;
    logic                               neg_reg;

    logic signed [smlv_pkg::MAG_W:0]    avg;
    logic signed [smlv_pkg::PROD_W-1:0] prod_next;
    logic signed [smlv_pkg::PROD_W-1:0] prod_reg;
    logic signed [smlv_pkg::PROD_W-1:0] scaled;

    // stage A: mix and filter sum
    always_comb begin
        raw = '0;
        if (ctrl.synth_en) begin
            raw = smlv_pkg::RAW_W'(synth);
        end
        if (ctrl.dac_valid) begin
            raw = raw + smlv_pkg::RAW_W'(dac);
        end
        case (ctrl.mode)
            smlv_pkg::MODE_AVG3: sum_next = smlv_pkg::SUM_W'(raw)
                + smlv_pkg::SUM_W'(hist_reg[0]) + smlv_pkg::SUM_W'(hist_reg[1]);
            smlv_pkg::MODE_AVG4: sum_next = smlv_pkg::SUM_W'(raw)
                + smlv_pkg::SUM_W'(hist_reg[0]) + smlv_pkg::SUM_W'(hist_reg[1])
                + smlv_pkg::SUM_W'(hist_reg[2]);
            default:             sum_next = smlv_pkg::SUM_W'(raw);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < smlv_pkg::HIST_D; i++) begin
                hist_reg[i] <= '0;
            end
        end else if (ctrl.ld_a) begin
            if (ctrl.mode == smlv_pkg::MODE_AVG3) begin
                if (ctrl.slot == smlv_pkg::SLOT_0) begin
                    hist_reg[0] <= raw;
                end else if (ctrl.slot == smlv_pkg::SLOT_1) begin
                    hist_reg[1] <= raw;
                end
            end else if (ctrl.mode == smlv_pkg::MODE_AVG4) begin
                if (ctrl.slot == smlv_pkg::SLOT_0) begin
                    hist_reg[0] <= raw;
                end else if (ctrl.slot == smlv_pkg::SLOT_1) begin
                    hist_reg[1] <= raw;
                end else if (ctrl.slot == smlv_pkg::SLOT_2) begin
                    hist_reg[2] <= raw;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld_a) begin
            sum_reg  <= sum_next;
            mode_reg <= ctrl.mode;
        end
    end

    // stage B: divide magnitude, truncation toward zero
    always_comb begin
        mag_full = sum_reg[smlv_pkg::SUM_W-1] ? smlv_pkg::SUM_W'(-sum_reg)
                                                : smlv_pkg::SUM_W'(sum_reg);
        prod3 = (smlv_pkg::MAG_W+smlv_pkg::RECIP3_W)'(mag_full[smlv_pkg::MAG_W-1:0])
              * (smlv_pkg::MAG_W+smlv_pkg::RECIP3_W)'(smlv_pkg::RECIP3);
        case (mode_reg)
            smlv_pkg::MODE_AVG3: mag_next = smlv_pkg::MAG_W'(prod3 >> smlv_pkg::RECIP3_SH);
            smlv_pkg::MODE_AVG4: mag_next = smlv_pkg::MAG_W'(mag_full >> 2);
            default:             mag_next = mag_full[smlv_pkg::MAG_W-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld_b) begin
            mag_reg <= mag_next;
            neg_reg <= sum_reg[smlv_pkg::SUM_W-1];
        end
    end

    // stage C: restore sign, apply volume
    always_comb begin
        avg = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
        prod_next = smlv_pkg::PROD_W'(avg) * smlv_pkg::PROD_W'($signed({1'b0, ctrl.vol}));
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld_c) begin
            prod_reg <= prod_next;
        end
    end

    // divide by 32 toward zero, then clamp
    always_comb begin
        scaled = (prod_reg + (prod_reg[smlv_pkg::PROD_W-1] ? smlv_pkg::PROD_W'(31)
                                                           : smlv_pkg::PROD_W'(0)))
                 >>> smlv_pkg::VOL_SH;
        if (scaled > smlv_pkg::OUT_MAX) begin
            sample = smlv_pkg::OUT_W'(smlv_pkg::OUT_MAX);
        end else if (scaled < smlv_pkg::OUT_MIN) begin
            sample = smlv_pkg::OUT_W'(smlv_pkg::OUT_MIN);
        end else begin
            sample = scaled[smlv_pkg::OUT_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== sv/smlv_out.sv =====
`default_nettype none
module smlv_out (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             c_valid,
    input  wire logic signed [smlv_pkg::OUT_W-1:0] c_left,
    input  wire logic signed [smlv_pkg::OUT_W-1:0] c_right,
    input  wire logic                             c_block_end,
    output logic                                  load,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [smlv_pkg::OUT_W-1:0]     m_out_left,
    output logic signed [smlv_pkg::OUT_W-1:0]     m_out_right,
    output logic                                  m_out_block_end
);

    logic valid_reg;
    logic signed [smlv_pkg::OUT_W-1:0] left_reg;
    logic signed [smlv_pkg::OUT_W-1:0] right_reg;
    logic be_reg;

    assign load = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= c_valid;
        end
    end

    // both lanes land in one result transaction
    always_ff @(posedge aclk) begin
        if (load) begin
            left_reg  <= c_left;
            right_reg <= c_right;
            be_reg    <= c_block_end;
        end
    end

    assign m_valid         = valid_reg;
    assign m_out_left      = left_reg;
    assign m_out_right     = right_reg;
    assign m_out_block_end = be_reg;

endmodule
`default_nettype wire

// ===== sv/stereo_mix_lowpass_volume_limit.sv =====
`default_nettype none
// Stereo mixer with moving-average low-pass, volume and 16-bit saturation.
// One input transaction carries a synthesizer pair (19-bit signed) and an
// optional DAC pair; one output transaction returns the processed pair plus
// the block_end marker. Throughput is one transaction per clock while m_ready
// keeps the output flowing; m_valid rises when the result reaches the last of four registers
// (mix/sum loaded at acceptance, divide, volume multiply, output register),
// with empty stages still taking new input while a result waits.
// Left and right run in two identical lanes
// that share slot control and merge in the output register. The history
// slots and the slot index update at input acceptance, so back-to-back
// samples see each other's history. Configuration (index 0 filter_mode,
// 1 volume_mul, 2 synth_enable; index 3 ignored) is always ready and must
// only be written while the block is idle.
module stereo_mix_lowpass_volume_limit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [1:0]                          cfg_index,
    input  wire logic [7:0]                          cfg_data,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [smlv_pkg::SYNTH_W-1:0] s_synth_left,
    input  wire logic signed [smlv_pkg::SYNTH_W-1:0] s_synth_right,
    input  wire logic                                s_dac_valid,
    input  wire logic signed [smlv_pkg::DAC_W-1:0]   s_dac_left,
    input  wire logic signed [smlv_pkg::DAC_W-1:0]   s_dac_right,
    input  wire logic                                s_block_end,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [smlv_pkg::OUT_W-1:0]        m_out_left,
    output logic signed [smlv_pkg::OUT_W-1:0]        m_out_right,
    output logic                                     m_out_block_end
);

    // config registers
    logic [1:0] mode_reg;
    logic [7:0] vol_reg;
    logic       synth_en_reg;

    // shared history slot pointer
    logic [1:0] slot_reg;
    logic [1:0] slot_next;

    // pipeline occupancy
    logic va_reg, vb_reg, vc_reg;
    logic be_a_reg, be_b_reg, be_c_reg;
    logic en_a, en_b, en_c, en_out;
    logic accept;

    smlv_pkg::lane_ctrl_t ctrl;
    logic signed [smlv_pkg::OUT_W-1:0] lane_left;
    logic signed [smlv_pkg::OUT_W-1:0] lane_right;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= smlv_pkg::MODE_PASS;
            vol_reg      <= smlv_pkg::VOLUME_RESET;
            synth_en_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                smlv_pkg::CFG_FILTER_MODE:  mode_reg     <= cfg_data[1:0];
                smlv_pkg::CFG_VOLUME_MUL:   vol_reg      <= cfg_data;
                smlv_pkg::CFG_SYNTH_ENABLE: synth_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // each stage moves when its successor frees up; bubbles collapse
    assign en_c    = !vc_reg || en_out;
    assign en_b    = !vb_reg || en_c;
    assign en_a    = !va_reg || en_b;
    assign s_ready = en_a;
    assign accept  = s_valid && en_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (en_a) va_reg <= s_valid;
            if (en_b) vb_reg <= va_reg;
            if (en_c) vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) be_a_reg <= s_block_end;
        if (en_b)   be_b_reg <= be_a_reg;
        if (en_c)   be_c_reg <= be_b_reg;
    end

    // slot sequencing: three-term toggles 0/1 and parks on 2,
    // four-term cycles 0-1-2, pass-through holds
    always_comb begin
        slot_next = slot_reg;
        case (mode_reg)
            smlv_pkg::MODE_AVG3: begin
                if (slot_reg == smlv_pkg::SLOT_0) begin
                    slot_next = smlv_pkg::SLOT_1;
                end else if (slot_reg == smlv_pkg::SLOT_1) begin
                    slot_next = smlv_pkg::SLOT_0;
                end
            end
            smlv_pkg::MODE_AVG4: begin
                if (slot_reg == smlv_pkg::SLOT_0) begin
                    slot_next = smlv_pkg::SLOT_1;
                end else if (slot_reg == smlv_pkg::SLOT_1) begin
                    slot_next = smlv_pkg::SLOT_2;
                end else if (slot_reg == smlv_pkg::SLOT_2) begin
                    slot_next = smlv_pkg::SLOT_0;
                end
            end
            default: slot_next = slot_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= smlv_pkg::SLOT_0;
        end else if (accept) begin
            slot_reg <= slot_next;
        end
    end

    always_comb begin
        ctrl.ld_a      = accept;
        ctrl.ld_b      = en_b;
        ctrl.ld_c      = en_c;
        ctrl.synth_en  = synth_en_reg;
        ctrl.dac_valid = s_dac_valid;
        ctrl.mode      = mode_reg;
        ctrl.slot      = slot_reg;
        ctrl.vol       = vol_reg;
    end

    smlv_lane u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .synth   (s_synth_left),
        .dac     (s_dac_left),
        .sample  (lane_left)
    );

    smlv_lane u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .synth   (s_synth_right),
        .dac     (s_dac_right),
        .sample  (lane_right)
    );

    smlv_out u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .c_valid         (vc_reg),
        .c_left          (lane_left),
        .c_right         (lane_right),
        .c_block_end     (be_c_reg),
        .load            (en_out),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_left      (m_out_left),
        .m_out_right     (m_out_right),
        .m_out_block_end (m_out_block_end)
    );

endmodule
`default_nettype wire
